>>> src/neighbor_link_quality_table_assert.svh
// ----------------------------------------------------------------------------
// Neighbor link quality table assertion macros
// Shorthand for clocked implication checks that are gated off during reset.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_LINK_QUALITY_TABLE_ASSERT_SVH
`define NEIGHBOR_LINK_QUALITY_TABLE_ASSERT_SVH

// Same-cycle implication.
`define NLQT_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("nlqt: implication check failed");

// Next-cycle implication.
`define NLQT_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("nlqt: next-cycle check failed");

`endif

>>> src/nlqt_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor link quality table package
// Sizes, operation and status codes, shared structs and count saturation.
// ----------------------------------------------------------------------------
package nlqt_pkg;

    // Table size and window length.
    localparam int MAX_NEIGHBORS = 16;
    localparam int WINDOW        = 100;

    localparam int ADDR_W  = 48;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 7;
    localparam int SLOT_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int WCNT_W  = $clog2(WINDOW + 1);

    // Input and output item packing.
    localparam int S_DATA_W = ((ADDR_W + 1 + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 + COUNT_W + 7) / 8) * 8;

    // Queue between the front and the back.
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Kind codes as they arrive on the input.
    localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_REGISTER,
        OP_RECORD,
        OP_QUERY,
        OP_IGNORE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // One classified item as it travels through the queue.
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic              outcome;
    } t_item;

    // Queue fill flags.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // Table occupancy seen from outside the back end.
    typedef struct packed {
        logic             full;
        logic [CNT_W-1:0] entry_count;
    } t_table_stat;

    // Clamp a window count to the width of the result field.
    function automatic logic [COUNT_W-1:0] sat_count(input logic [WCNT_W-1:0] c);
        logic [WCNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, c};
        if (wide > {{WCNT_W{1'b0}}, COUNT_MAX}) begin
            return COUNT_MAX;
        end
        return wide[COUNT_W-1:0];
    endfunction

endpackage

>>> src/nlqt_fifo.sv
// ----------------------------------------------------------------------------
// Neighbor link quality table item queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module nlqt_fifo
    import nlqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    input  logic        i_pop,
    output t_item       o_item,
    output t_queue_stat o_stat
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    // Flags and qualified strobes.
    assign o_stat.full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rd_ptr];

    // Storage is payload only.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/nlqt_front.sv
// ----------------------------------------------------------------------------
// Neighbor link quality table front end
// Accepts input items, decodes the kind into an operation and feeds the queue.
// ----------------------------------------------------------------------------
module nlqt_front
    import nlqt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [S_DATA_W-1:0] i_data,
    input  logic [KIND_W-1:0]   i_kind,
    input  t_queue_stat         i_qstat,
    output logic                o_push,
    output t_item               o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Classify the incoming item.
    always_comb begin
        n_item.addr    = i_data[ADDR_W-1:0];
        n_item.outcome = i_data[ADDR_W];
        case (i_kind)
            KIND_REGISTER: n_item.op = OP_REGISTER;
            KIND_RECORD:   n_item.op = OP_RECORD;
            KIND_QUERY:    n_item.op = OP_QUERY;
            default:       n_item.op = OP_IGNORE;
        endcase
    end

    // The holding register drains into the queue whenever it has room.
    assign o_push  = r_valid && !i_qstat.full;
    assign o_ready = !r_valid || !i_qstat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

>>> src/nlqt_back.sv
// ----------------------------------------------------------------------------
// Neighbor link quality table back end
// Scans the address table one entry a cycle, registers new entries, updates the
// window and count of the matching entry and holds the result in an output register.
// ----------------------------------------------------------------------------
module nlqt_back
    import nlqt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_queue_stat         i_qstat,
    input  t_item               i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [M_DATA_W-1:0] o_data,
    output t_table_stat         o_stat
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_EXEC
    } t_bstate;

    t_bstate             r_state;
    t_item               r_item;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_entry_cnt;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_found;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [COUNT_W-1:0]  r_out_count;

    // Per-entry address, outcome window (bit 0 oldest) and success count.
    logic [ADDR_W-1:0]   r_addr_mem [MAX_NEIGHBORS];
    logic [WINDOW-1:0]   r_row_mem  [MAX_NEIGHBORS];
    logic [WCNT_W-1:0]   r_cnt_mem  [MAX_NEIGHBORS];

    logic [WINDOW-1:0]   n_row;
    logic [WCNT_W-1:0]   n_cnt;
    logic                out_free;
    logic                table_full;
    logic [SLOT_W-1:0]   new_slot;

    assign out_free   = !r_out_valid || i_ready;
    assign table_full = (r_entry_cnt == CNT_W'(MAX_NEIGHBORS));
    assign new_slot   = r_entry_cnt[SLOT_W-1:0];
    assign o_pop      = (r_state == B_IDLE) && !i_qstat.empty;
    assign o_valid    = r_out_valid;
    assign o_data     = M_DATA_W'({r_out_count, r_out_status});
    assign o_stat.full        = table_full;
    assign o_stat.entry_count = r_entry_cnt;

    // Window after recording one outcome, and its running count.
    always_comb begin
        for (int j = 0; j < WINDOW - 1; j++) begin
            n_row[j] = r_row_mem[r_slot][j + 1];
        end
        n_row[WINDOW-1] = r_item.outcome;
        n_cnt = r_cnt_mem[r_slot] - WCNT_W'(r_row_mem[r_slot][0])
                + WCNT_W'(r_item.outcome);
    end

    // Sequencer with the table count and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_entry_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register loads an answer or empties once it is taken.
            if (r_state == B_EXEC && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_state <= (i_item.op == OP_IGNORE) ? B_EXEC : B_SCAN;
                    end
                end
                B_SCAN: begin
                    if (r_idx == r_entry_cnt) begin
                        r_state <= B_EXEC;
                    end else if (r_addr_mem[r_idx[SLOT_W-1:0]] == r_item.addr) begin
                        r_state <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                        if (r_item.op == OP_REGISTER && !r_found && !table_full) begin
                            r_entry_cnt <= r_entry_cnt + 1'b1;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Payload registers: current item, scan position, table contents, result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_item  <= i_item;
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            B_SCAN: begin
                if (r_idx != r_entry_cnt) begin
                    if (r_addr_mem[r_idx[SLOT_W-1:0]] == r_item.addr) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx[SLOT_W-1:0];
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            B_EXEC: begin
                if (out_free) begin
                    case (r_item.op)
                        OP_REGISTER: begin
                            if (r_found) begin
                                r_out_status <= ST_OK;
                                r_out_count  <= sat_count(r_cnt_mem[r_slot]);
                            end else if (!table_full) begin
                                r_addr_mem[new_slot] <= r_item.addr;
                                r_row_mem[new_slot]  <= '1;
                                r_cnt_mem[new_slot]  <= WCNT_W'(WINDOW);
                                r_out_status <= ST_OK;
                                r_out_count  <= sat_count(WCNT_W'(WINDOW));
                            end else begin
                                r_out_status <= ST_FULL;
                                r_out_count  <= '0;
                            end
                        end
                        OP_RECORD: begin
                            if (r_found) begin
                                r_row_mem[r_slot] <= n_row;
                                r_cnt_mem[r_slot] <= n_cnt;
                                r_out_status <= ST_OK;
                                r_out_count  <= sat_count(n_cnt);
                            end else begin
                                r_out_status <= ST_NOT_FOUND;
                                r_out_count  <= '0;
                            end
                        end
                        OP_QUERY: begin
                            if (r_found) begin
                                r_out_status <= ST_OK;
                                r_out_count  <= sat_count(r_cnt_mem[r_slot]);
                            end else begin
                                r_out_status <= ST_NOT_FOUND;
                                r_out_count  <= '0;
                            end
                        end
                        default: begin
                            r_out_status <= ST_OK;
                            r_out_count  <= '0;
                        end
                    endcase
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

>>> src/neighbor_link_quality_table.sv
// An accepted item passes through the front end holding register and the queue
// to the back end, which starts, compares table entries one at a time (up to
// MAX_NEIGHBORS, with a final end-of-table step when the address is absent and
// no scan for the unused kind), then updates and answers. The back end finishes
// one item before it takes the next; the front end and the queue can still accept items meanwhile. Reset is
// synchronous, active low; it empties the table and the queue, no clearing pass.
// ----------------------------------------------------------------------------
// Neighbor link quality table
// Per-neighbor sliding window of transfer outcomes with success counts.
// ----------------------------------------------------------------------------
`include "neighbor_link_quality_table_assert.svh"

module neighbor_link_quality_table
    import nlqt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // neighbor_address[47:0], outcome[48], zeros
    input  logic [KIND_W-1:0]   s_tuser,   // kind[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[1:0], success_count[8:2], zeros
);

    logic        push;
    logic        pop;
    t_item       front_item;
    t_item       queue_item;
    t_queue_stat qstat;
    t_table_stat tstat;

    // Front end: accept and classify.
    nlqt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .i_kind  (s_tuser),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (front_item)
    );

    // Queue between the two halves.
    nlqt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (qstat)
    );

    // Back end: search, update and answer.
    nlqt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_item  (queue_item),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata),
        .o_stat  (tstat)
    );

    // Queue strobes only act on a queue that can take them.
    `NLQT_ASSERT_IMP(a_push_not_full, push, !qstat.full)
    `NLQT_ASSERT_IMP(a_pop_not_empty, pop, !qstat.empty)
    // A full answer only comes from a table at capacity.
    `NLQT_ASSERT_IMP(a_full_status, m_tvalid && (m_tdata[1:0] == ST_FULL), tstat.full)
    // The table never grows past capacity once full.
    `NLQT_ASSERT_NEXT(a_full_stays, tstat.full, tstat.entry_count == CNT_W'(MAX_NEIGHBORS))

endmodule
